// File: design/tcrs_pkg.sv
// Shared types and constants for the texture copy region splitter.
package tcrs_pkg;

  // Defaults for the top-level parameters
  localparam int PLACEMENT_ALIGN_DEF = 512;
  localparam int QUEUE_DEPTH_DEF     = 4;

  // Front pipeline: input stage plus 11 work stages
  localparam int FRONT_LAT = 11;
  // Quotient bits resolved per divider stage
  localparam int DIV_BPS   = 4;
  // Remainder of the offset against the alignment never exceeds 16 bits
  localparam int REL_W     = 16;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_VOLUME = 2'd1,
    ST_BAD    = 2'd2
  } status_t;

  // One copy request as it enters the front
  typedef struct packed {
    logic [15:0] tex_x;
    logic [15:0] tex_y;
    logic [15:0] tex_z;
    logic [15:0] region_width;
    logic [15:0] region_height;
    logic [15:0] region_depth;
    logic [4:0]  texel_bytes;
    logic [31:0] byte_offset;
    logic [31:0] row_pitch;
  } req_t;

  // Classified request handed from front to back
  typedef struct packed {
    status_t     status;
    logic        split;
    logic [31:0] base;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] tx;
    logic [15:0] ty;
    logic [15:0] tz;
    logic [31:0] rpt;
  } entry_t;

  // One emitted copy record
  typedef struct packed {
    status_t     status;
    logic        last;
    logic [31:0] buffer_base;
    logic [16:0] dest_x;
    logic [15:0] dest_y;
    logic [15:0] copy_width;
    logic [15:0] copy_height;
    logic [31:0] buf_x;
    logic [15:0] buf_y;
    logic [15:0] buf_z;
    logic [31:0] foot_width;
    logic [16:0] foot_height;
  } rec_t;

endpackage

// File: design/tcrs_div.sv
// Pipelined restoring divider, BPS quotient bits per stage.
module tcrs_div import tcrs_pkg::*; #(
  parameter int NW  = 16,
  parameter int DW  = 16,
  parameter int BPS = DIV_BPS
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);

  localparam int NS = NW / BPS;

  // Numerator shifts out at the top while quotient bits shift in below
  logic [NW-1:0] nq [1:NS];
  logic [DW:0]   r  [1:NS];
  logic [DW-1:0] d  [1:NS];

  for (genvar g = 0; g < NS; g++) begin : g_stage
    logic [NW-1:0] src_nq;
    logic [DW:0]   src_r;
    logic [DW-1:0] src_d;
    logic [NW-1:0] nq_c;
    logic [DW:0]   r_c;

    if (g == 0) begin : g_first
      assign src_nq = num;
      assign src_r  = '0;
      assign src_d  = den;
    end else begin : g_next
      assign src_nq = nq[g];
      assign src_r  = r[g];
      assign src_d  = d[g];
    end

    // Resolve BPS quotient bits
    always_comb begin
      nq_c = src_nq;
      r_c  = src_r;
      for (int i = 0; i < BPS; i++) begin
        r_c  = {r_c[DW-1:0], nq_c[NW-1]};
        nq_c = {nq_c[NW-2:0], 1'b0};
        if (r_c >= {1'b0, src_d}) begin
          r_c     = r_c - {1'b0, src_d};
          nq_c[0] = 1'b1;
        end
      end
    end

    // Advance the stage
    always_ff @(posedge clk) begin
      if (en) begin
        nq[g+1] <= nq_c;
        r[g+1]  <= r_c;
        d[g+1]  <= src_d;
      end
    end
  end

  assign quo = nq[NS];
  assign rem = r[NS][DW-1:0];

endmodule

// File: design/tcrs_front.sv
// Front pipeline: align the offset, run the divisions, classify the request.
module tcrs_front import tcrs_pkg::*; #(
  parameter int PLACEMENT_ALIGN = PLACEMENT_ALIGN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  req_t        req,
  output logic        full,
  output logic        q_push,
  output entry_t      q_entry,
  input  logic        q_full
);

  // Reciprocal of the alignment; estimate is low by at most one
  localparam logic [63:0] RECIP64 = 64'((64'd1 << 32) / PLACEMENT_ALIGN);
  localparam logic [31:0] RECIP   = RECIP64[31:0];
  localparam logic [17:0] ALIGN18 = 18'(PLACEMENT_ALIGN);
  localparam logic [16:0] ALIGN17 = 17'(PLACEMENT_ALIGN);

  logic              en;
  logic [FRONT_LAT:0] v;
  req_t              req_s [0:FRONT_LAT];
  logic [REL_W-1:0]  rel_s [3:FRONT_LAT];
  logic [63:0]       prod1;
  logic [31:0]       qa2;
  logic [31:0]       diff_c;
  logic [17:0]       r18_c;
  logic [REL_W-1:0]  rel_c;

  // Stall the whole pipe only when the last stage cannot drain
  assign en     = !(v[FRONT_LAT] && q_full);
  assign full   = !en;
  assign q_push = v[FRONT_LAT] && en;

  // Remainder of offset against the alignment, one correction
  always_comb begin
    diff_c = req_s[2].byte_offset - qa2;
    r18_c  = diff_c[17:0];
    if (r18_c >= ALIGN18) begin
      r18_c = r18_c - ALIGN18;
    end
    rel_c = r18_c[REL_W-1:0];
  end

  // Hold valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[FRONT_LAT-1:0], push};
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      req_s[0] <= req;
      for (int i = 1; i <= FRONT_LAT; i++) begin
        req_s[i] <= req_s[i-1];
      end
      prod1    <= req_s[0].byte_offset * RECIP;
      qa2      <= 32'(prod1[63:32] * ALIGN17);
      rel_s[3] <= rel_c;
      for (int i = 4; i <= FRONT_LAT; i++) begin
        rel_s[i] <= rel_s[i-1];
      end
    end
  end

  // Row pitch in texels and pitch check
  logic [31:0] rpt;
  logic [4:0]  pmod;
  tcrs_div #(.NW(32), .DW(5), .BPS(DIV_BPS)) u_div_rpt (
    .clk (clk),
    .en  (en),
    .num (req_s[3].row_pitch),
    .den (req_s[3].texel_bytes),
    .quo (rpt),
    .rem (pmod)
  );

  // Whole pitch rows inside the remainder
  logic [15:0] k_raw;
  logic [15:0] bxb_raw;
  tcrs_div #(.NW(16), .DW(16), .BPS(DIV_BPS)) u_div_rows (
    .clk (clk),
    .en  (en),
    .num (rel_s[3]),
    .den (req_s[3].row_pitch[15:0]),
    .quo (k_raw),
    .rem (bxb_raw)
  );

  // A pitch beyond 16 bits exceeds any remainder
  logic        big;
  logic [15:0] k7;
  logic [15:0] bxb7;
  assign big  = req_s[7].row_pitch[31:16] != '0;
  assign k7   = big ? '0 : k_raw;
  assign bxb7 = big ? rel_s[7] : bxb_raw;

  // Slice and row inside the footprint
  logic [15:0] tz;
  logic [15:0] ty;
  tcrs_div #(.NW(16), .DW(16), .BPS(DIV_BPS)) u_div_slice (
    .clk (clk),
    .en  (en),
    .num (k7),
    .den (req_s[7].region_height),
    .quo (tz),
    .rem (ty)
  );

  // Texel column inside the footprint
  logic [15:0] tx;
  logic [4:0]  tx_rem;
  tcrs_div #(.NW(16), .DW(5), .BPS(DIV_BPS)) u_div_col (
    .clk (clk),
    .en  (en),
    .num (bxb7),
    .den (req_s[7].texel_bytes),
    .quo (tx),
    .rem (tx_rem)
  );

  // Classify and build the queue entry
  req_t        rq;
  logic        vol;
  logic        bad;
  logic        fits;
  logic [32:0] wsum;
  always_comb begin
    rq   = req_s[FRONT_LAT];
    vol  = (rq.tex_z != '0) || (rq.region_depth > 16'd1);
    bad  = (rq.texel_bytes == '0) || (rq.row_pitch == '0) || (pmod != '0) ||
           (rq.region_height == '0) || (tx_rem != tx_rem);
    wsum = 33'(rq.region_width) + 33'(tx);
    fits = wsum <= 33'(rpt);
    q_entry = '0;
    if (vol) begin
      q_entry.status = ST_VOLUME;
    end else if (bad) begin
      q_entry.status = ST_BAD;
    end else begin
      q_entry.status = ST_OK;
      q_entry.split  = (rel_s[FRONT_LAT] != '0) && !fits;
      q_entry.base   = rq.byte_offset - 32'(rel_s[FRONT_LAT]);
      q_entry.x      = rq.tex_x;
      q_entry.y      = rq.tex_y;
      q_entry.w      = rq.region_width;
      q_entry.h      = rq.region_height;
      q_entry.tx     = tx;
      q_entry.ty     = ty;
      q_entry.tz     = tz;
      q_entry.rpt    = rpt;
    end
  end

endmodule

// File: design/tcrs_queue.sv
// Short request queue between front and back.
module tcrs_queue import tcrs_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t din,
  output logic   full,
  input  logic   pop,
  output entry_t dout,
  output logic   empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  entry_t        mem [0:DEPTH-1];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = count == DEPTH_C;
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

// File: design/tcrs_back.sv
// Back end: expand each queued request into one or two copy records.
module tcrs_back import tcrs_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   q_empty,
  input  entry_t q_head,
  output logic   q_pop,
  input  logic   pop,
  output logic   empty,
  output rec_t   rec
);

  logic        out_valid;
  logic        out_valid_next;
  logic        phase;
  logic        phase_next;
  logic        load;
  rec_t        rec_next;
  rec_t        rec0;
  rec_t        rec1;
  logic [31:0] w0;
  logic [15:0] w1;

  assign empty = !out_valid;
  assign load  = !out_valid || pop;

  // Build both records of the head request
  always_comb begin
    w0 = q_head.rpt - 32'(q_head.tx);
    w1 = q_head.w - w0[15:0];

    rec0.status      = q_head.status;
    rec0.last        = !q_head.split;
    rec0.buffer_base = q_head.base;
    rec0.dest_x      = 17'(q_head.x);
    rec0.dest_y      = q_head.y;
    rec0.copy_width  = q_head.split ? w0[15:0] : q_head.w;
    rec0.copy_height = q_head.h;
    rec0.buf_x       = 32'(q_head.tx);
    rec0.buf_y       = q_head.ty;
    rec0.buf_z       = q_head.tz;
    rec0.foot_width  = q_head.split ? q_head.rpt : 32'(q_head.w) + 32'(q_head.tx);
    rec0.foot_height = 17'(q_head.h) + 17'(q_head.ty);

    rec1.status      = q_head.status;
    rec1.last        = 1'b1;
    rec1.buffer_base = q_head.base;
    rec1.dest_x      = 17'(q_head.x) + 17'(w0[15:0]);
    rec1.dest_y      = q_head.y;
    rec1.copy_width  = w1;
    rec1.copy_height = q_head.h;
    rec1.buf_x       = '0;
    rec1.buf_y       = q_head.ty + 16'd1;
    rec1.buf_z       = q_head.tz;
    rec1.foot_width  = 32'(w1);
    rec1.foot_height = 17'(q_head.h) + 17'(q_head.ty) + 17'd1;
  end

  // Pick the next record and drop finished requests
  always_comb begin
    out_valid_next = out_valid;
    phase_next     = phase;
    rec_next       = rec;
    q_pop          = 1'b0;
    if (load) begin
      out_valid_next = !q_empty;
      if (!q_empty) begin
        if (phase) begin
          rec_next   = rec1;
          q_pop      = 1'b1;
          phase_next = 1'b0;
        end else begin
          rec_next = rec0;
          if (q_head.split) begin
            phase_next = 1'b1;
          end else begin
            q_pop = 1'b1;
          end
        end
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      phase     <= phase_next;
    end
  end

  // Hold the output record
  always_ff @(posedge clk) begin
    rec <= rec_next;
  end

endmodule

// File: design/texture_copy_region_splitter_core.sv
// Splits a buffer-to-texture copy request into one or two copy records.
// A request is taken in every cycle that full is low; on its way to the result
// ports it passes the input register, the 11-stage front pipe, the queue write
// and the result register. The front pipe holds the offset alignment
// (reciprocal multiply and one correction) and pipelined restoring dividers
// that resolve 4 quotient bits per stage. The result port gives one record
// per cycle while pop is high and records are waiting; a request yields one record,
// or two when the rows straddle the pitch. Volume copies and bad pitch, texel size
// or height give a single record with an error status.
// PLACEMENT_ALIGN may be any value from 2 to 65536; QUEUE_DEPTH sets the
// number of requests buffered between classification and record output.
module texture_copy_region_splitter_core import tcrs_pkg::*; #(
  parameter int PLACEMENT_ALIGN = PLACEMENT_ALIGN_DEF,
  parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [15:0] tex_x,
  input  logic [15:0] tex_y,
  input  logic [15:0] tex_z,
  input  logic [15:0] region_width,
  input  logic [15:0] region_height,
  input  logic [15:0] region_depth,
  input  logic [4:0]  texel_bytes,
  input  logic [31:0] byte_offset,
  input  logic [31:0] row_pitch,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status,
  output logic        last,
  output logic [31:0] buffer_base,
  output logic [16:0] dest_x,
  output logic [15:0] dest_y,
  output logic [15:0] copy_width,
  output logic [15:0] copy_height,
  output logic [31:0] buf_x,
  output logic [15:0] buf_y,
  output logic [15:0] buf_z,
  output logic [31:0] foot_width,
  output logic [16:0] foot_height
);

  req_t   req;
  logic   q_push;
  logic   q_full;
  logic   q_pop;
  logic   q_empty;
  entry_t q_in;
  entry_t q_head;
  rec_t   rec;

  // Gather the request fields
  always_comb begin
    req.tex_x         = tex_x;
    req.tex_y         = tex_y;
    req.tex_z         = tex_z;
    req.region_width  = region_width;
    req.region_height = region_height;
    req.region_depth  = region_depth;
    req.texel_bytes   = texel_bytes;
    req.byte_offset   = byte_offset;
    req.row_pitch     = row_pitch;
  end

  tcrs_front #(.PLACEMENT_ALIGN(PLACEMENT_ALIGN)) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .req     (req),
    .full    (full),
    .q_push  (q_push),
    .q_entry (q_in),
    .q_full  (q_full)
  );

  tcrs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_head),
    .empty (q_empty)
  );

  tcrs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .rec     (rec)
  );

  // Drive the result ports
  assign status      = rec.status;
  assign last        = rec.last;
  assign buffer_base = rec.buffer_base;
  assign dest_x      = rec.dest_x;
  assign dest_y      = rec.dest_y;
  assign copy_width  = rec.copy_width;
  assign copy_height = rec.copy_height;
  assign buf_x       = rec.buf_x;
  assign buf_y       = rec.buf_y;
  assign buf_z       = rec.buf_z;
  assign foot_width  = rec.foot_width;
  assign foot_height = rec.foot_height;

endmodule

// File: design/tcrs_checker.sv
// Port-level checks for the copy region splitter, bound to the top level.
module tcrs_checker import tcrs_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  status,
  input logic        last,
  input logic [15:0] copy_width
);

  // No record is shown right after reset
  a_empty_after_reset: assert property (@(posedge clk) $past(rst) |-> empty)
    else $error("record shown right after reset");

  // A waiting record holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(copy_width) && $stable(last)))
    else $error("waiting record changed");

  // Error records stand alone
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != ST_OK) |-> last)
    else $error("error record not marked last");

  // The second half of a split follows at once
  a_split_follow: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !last) |=> (!empty && status == ST_OK))
    else $error("second record of a split missing");

endmodule

bind texture_copy_region_splitter_core tcrs_checker u_tcrs_checker (
  .clk        (clk),
  .rst        (rst),
  .empty      (empty),
  .pop        (pop),
  .status     (status),
  .last       (last),
  .copy_width (copy_width)
);

// File: dv/texture_copy_region_splitter_core_test.sv
// Testbench for the texture copy region splitter: random and directed requests, scoreboard.
module texture_copy_region_splitter_core_test;
  import tcrs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ALIGN = PLACEMENT_ALIGN_DEF;

  // Tracks expected copy records and flags mismatches
  class copy_record_board;
    rec_t pending[$];
    int errors;

    function void note_request(req_t r);
      logic [63:0] x, w, h, tb, off, pitch, rel, base, slice, bxb, rest, byb, tx, ty, tz;
      logic [63:0] rpt, w0, w1;
      rec_t rec;
      x = 64'(r.tex_x); w = 64'(r.region_width); h = 64'(r.region_height);
      tb = 64'(r.texel_bytes); off = 64'(r.byte_offset); pitch = 64'(r.row_pitch);
      rec = '0;
      rec.last = 1'b1;
      if (r.tex_z != 0 || r.region_depth > 1) begin
        rec.status = ST_VOLUME;
        pending.push_back(rec);
        return;
      end
      if (tb == 0 || pitch == 0 || (pitch % tb) != 0 || h == 0) begin
        rec.status = ST_BAD;
        pending.push_back(rec);
        return;
      end
      rel = off % ALIGN;
      base = off - rel;
      rec.status = ST_OK;
      rec.buffer_base = 32'(base);
      rec.dest_x = 17'(x);
      rec.dest_y = r.tex_y;
      rec.copy_width = 16'(w);
      rec.copy_height = 16'(h);
      if (rel == 0) begin
        rec.foot_width = 32'(w);
        rec.foot_height = 17'(h);
        pending.push_back(rec);
        return;
      end
      slice = pitch * h;
      bxb = rel % pitch;
      rest = rel - bxb;
      byb = rest % slice;
      tx = bxb / tb;
      ty = byb / pitch;
      tz = (rest - byb) / slice;
      rpt = pitch / tb;
      rec.buf_x = 32'(tx);
      rec.buf_y = 16'(ty);
      rec.buf_z = 16'(tz);
      rec.foot_height = 17'(h + ty);
      if (w + tx <= rpt) begin
        rec.foot_width = 32'(w + tx);
        pending.push_back(rec);
        return;
      end
      w0 = rpt - tx;
      w1 = w - w0;
      rec.last = 1'b0;
      rec.copy_width = 16'(w0);
      rec.foot_width = 32'(rpt);
      pending.push_back(rec);
      rec.last = 1'b1;
      rec.dest_x = 17'(x + w0);
      rec.copy_width = 16'(w1);
      rec.buf_x = '0;
      rec.buf_y = 16'(ty + 1);
      rec.foot_width = 32'(w1);
      rec.foot_height = 17'(h + ty + 1);
      pending.push_back(rec);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch on %s: got %0h, expected %0h", what, got, want);
      errors++;
    endtask

    task check_record(rec_t got);
      rec_t want;
      if (pending.size() == 0) begin
        report("unexpected record", 1, 0);
        return;
      end
      want = pending.pop_front();
      if (got.status != want.status) report("status", got.status, want.status);
      if (got.last != want.last) report("last", got.last, want.last);
      if (got.buffer_base != want.buffer_base)
        report("buffer_base", got.buffer_base, want.buffer_base);
      if (got.dest_x != want.dest_x) report("dest_x", got.dest_x, want.dest_x);
      if (got.dest_y != want.dest_y) report("dest_y", got.dest_y, want.dest_y);
      if (got.copy_width != want.copy_width)
        report("copy_width", got.copy_width, want.copy_width);
      if (got.copy_height != want.copy_height)
        report("copy_height", got.copy_height, want.copy_height);
      if (got.buf_x != want.buf_x) report("buf_x", got.buf_x, want.buf_x);
      if (got.buf_y != want.buf_y) report("buf_y", got.buf_y, want.buf_y);
      if (got.buf_z != want.buf_z) report("buf_z", got.buf_z, want.buf_z);
      if (got.foot_width != want.foot_width)
        report("foot_width", got.foot_width, want.foot_width);
      if (got.foot_height != want.foot_height)
        report("foot_height", got.foot_height, want.foot_height);
    endtask
  endclass

  logic clk, rst, push, full, empty, pop, last;
  logic [15:0] tex_x, tex_y, tex_z, region_width, region_height, region_depth;
  logic [4:0] texel_bytes;
  logic [31:0] byte_offset, row_pitch, buffer_base, buf_x, foot_width;
  logic [1:0] status;
  logic [16:0] dest_x, foot_height;
  logic [15:0] dest_y, copy_width, copy_height, buf_y, buf_z;

  copy_record_board board;
  int push_idle_pct, pop_idle_pct;
  bit hold_pop, sending_done;

  texture_copy_region_splitter_core DUT (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Watchdog on the whole run
  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  // Offer one request and hold it until it is taken; push stays high between requests unless an idle gap is drawn
  task send_request(req_t r);
    if ($urandom_range(99) < push_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < push_idle_pct);
    end
    push <= 1'b1;
    {tex_x, tex_y, tex_z, region_width, region_height, region_depth,
     texel_bytes, byte_offset, row_pitch} <= r;
    do @(posedge clk); while (full);
    board.note_request(r);
  endtask

  function automatic logic [15:0] pick16();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'hffff;
      2: return 16'($urandom_range(1, 8));
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly legal requests with pitches near the offset remainder, so splits are common
  function automatic req_t random_request();
    req_t r;
    int sel;
    r.tex_x = pick16();
    r.tex_y = pick16();
    r.tex_z = ($urandom_range(19) == 0) ? pick16() : 16'd0;
    r.region_depth = ($urandom_range(19) == 0) ? pick16() : 16'($urandom_range(1));
    r.texel_bytes = ($urandom_range(29) == 0) ? 5'($urandom_range(31))
                                              : 5'($urandom_range(1, 16));
    r.region_height = ($urandom_range(29) == 0) ? 16'd0 :
                      ($urandom_range(3) == 0) ? pick16() : 16'($urandom_range(1, 4));
    r.region_width = ($urandom_range(2) == 0) ? pick16() : 16'($urandom_range(1, 64));
    r.byte_offset = $urandom;
    sel = $urandom_range(4);
    if (sel == 0) r.row_pitch = $urandom;
    else if (sel == 1 && r.texel_bytes != 0)
      r.row_pitch = 32'hffffffff - (32'hffffffff % r.texel_bytes);
    else r.row_pitch = r.texel_bytes * $urandom_range(1, 80);
    if ($urandom_range(29) == 0) r.row_pitch = 0;
    if ($urandom_range(9) == 0) r.byte_offset = r.byte_offset & ~32'(ALIGN - 1);
    return r;
  endfunction

  function automatic req_t make_request(logic [15:0] x, y, z, w, h, d, logic [4:0] tb,
                                        logic [31:0] off, pitch);
    return {x, y, z, w, h, d, tb, off, pitch};
  endfunction

  // Receiver: random pops, with a long hold-off when asked
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty)
        board.check_record({status, last, buffer_base, dest_x, dest_y, copy_width,
                            copy_height, buf_x, buf_y, buf_z, foot_width, foot_height});
      pop <= !hold_pop && ($urandom_range(99) >= pop_idle_pct);
    end
  end

  // Hold off the receiver for a long stretch while requests keep coming
  initial begin
    hold_pop = 1'b0;
    wait (!rst);
    repeat (300) @(posedge clk);
    hold_pop = 1'b1;
    repeat (200) @(posedge clk);
    hold_pop = 1'b0;
  end

  initial begin
    int phase, i, wait_cycles;
    board = new();
    rst = 1'b1;
    push = 1'b0;
    {tex_x, tex_y, tex_z, region_width, region_height, region_depth,
     texel_bytes, byte_offset, row_pitch} = '0;
    push_idle_pct = 29;
    pop_idle_pct = 65;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, errors, aligned, split, large slice pitch
    send_request(make_request(0, 0, 1, 4, 4, 1, 4, 0, 64));
    send_request(make_request(0, 0, 0, 4, 4, 2, 4, 0, 64));
    send_request(make_request(0, 0, 16'hffff, 4, 4, 16'hffff, 4, 0, 64));
    send_request(make_request(0, 0, 0, 4, 4, 1, 0, 0, 64));
    send_request(make_request(0, 0, 0, 4, 4, 1, 4, 0, 0));
    send_request(make_request(0, 0, 0, 4, 4, 1, 3, 0, 64));
    send_request(make_request(0, 0, 0, 4, 0, 1, 4, 0, 64));
    send_request(make_request(5, 6, 0, 7, 8, 0, 4, 32'h1000, 64));
    send_request(make_request(16'hffff, 16'hffff, 0, 16'hffff, 16'hffff, 1, 16,
                              32'hffffffff, 32'hfffffff0));
    send_request(make_request(1, 2, 0, 4, 2, 1, 4, 32'd40, 64));
    send_request(make_request(16'hffff, 3, 0, 16'hffff, 1, 1, 4, 32'd60, 64));
    send_request(make_request(0, 0, 0, 2, 1, 1, 1, 32'd511, 3));
    send_request(make_request(9, 9, 0, 10, 16'hffff, 1, 16, 32'h7fff_01ff, 32'h0100_0000));
    send_request(make_request(0, 0, 0, 0, 1, 1, 1, 32'd300, 32'd100));
    send_request(make_request(0, 0, 0, 20, 1, 1, 8, 32'd511, 32'd160));
    send_request(make_request(0, 0, 0, 1, 1, 1, 16, 32'hffff_fe00, 32'hffff_fff0));

    for (phase = 0; phase < 3; phase++) begin
      push_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 65 : 0;
      pop_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 29 : 0;
      for (i = 0; i < 512; i++) send_request(random_request());
    end
    push <= 1'b0;

    // Drain and allow for late stray records
    wait_cycles = 0;
    while (board.pending.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (40) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule

// File: sim.f
design/tcrs_pkg.sv
design/tcrs_div.sv
design/tcrs_front.sv
design/tcrs_queue.sv
design/tcrs_back.sv
design/texture_copy_region_splitter_core.sv
design/tcrs_checker.sv
dv/texture_copy_region_splitter_core_test.sv
